[src/pcs_pkg.sv]
// Package for the polyline collinear simplifier: widths, codes, word types and states.
`default_nettype none

package pcs_pkg;

  // Coordinate format
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Configuration registers
  localparam int TOL_BITS        = 32;
  localparam int LIMIT_BITS      = 10;
  localparam int RUN_BITS        = 11;
  localparam int CFG_ADDR_BITS   = 2;
  localparam int CFG_DATA_BITS   = 32;
  localparam logic [LIMIT_BITS-1:0] RUN_LIMIT_RESET = LIMIT_BITS'(10);

  // Register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SLOPE_TOL  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_RUN_LIMIT  = CFG_ADDR_BITS'(1);

  // Input word: one polyline point
  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         final_point;
  } point_t;

  // Output word: one kept point
  typedef struct packed {
    logic signed [COORD_BITS-1:0] kept_x;
    logic signed [COORD_BITS-1:0] kept_y;
    logic                         end_of_line;
  } kept_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MAG,
    ST_DIV,
    ST_FIX,
    ST_SDIFF,
    ST_DECIDE,
    ST_EMIT_PREV,
    ST_EMIT_ITEM
  } state_e;

endpackage

`default_nettype wire

[src/polyline_collinear_simplifier.sv]
// Top level of the polyline collinear simplifier: sequencer, serial divider, output register.
//
// Points of a polyline enter on the input channel (in_valid_i / in_stall_o), one word per
// point, the last one flagged by final_point. Kept points leave on the output channel
// (out_valid_o / out_stall_i), the last kept point flagged by end_of_line. A word moves at a
// rising edge where valid is high and stall is low.
// The first point of a line goes from the EMIT_ITEM state into the output register; the second point
// of a line is absorbed at once unless it is the last one. Every later point needs two slope
// quotients from one shared radix-2 divider that retires one quotient bit per cycle, so the
// input stalls while both quotients are formed and while the kept points it yields are loaded;
// points go one at a time, and the next point is not taken before the last one is done.
// A point yields at most two kept points, which pass through a single output register. The
// next point is taken while the last kept point still waits there; a stalled receiver holds
// the block only when another kept point has to go out.
// Reset clears the configuration (tolerance 0, run limit 10), the line state and the output
// register, so the next point starts a new line. Write configuration only while idle.
`default_nettype none

module polyline_collinear_simplifier #(
  parameter int FRAC_BITS = pcs_pkg::FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // point channel
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire pcs_pkg::point_t                    in_data_i,
  // kept point channel
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      pcs_pkg::kept_t                     out_data_o,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [pcs_pkg::CFG_ADDR_BITS-1:0]  cfg_idx_i,
  input  wire logic [pcs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int CB       = pcs_pkg::COORD_BITS;
  localparam int DW       = CB + 1;
  localparam int NUM_BITS = CB + 1 + FRAC_BITS;
  localparam int CNT_BITS = $clog2(NUM_BITS);
  localparam int CW       = ((DW > pcs_pkg::TOL_BITS) ? DW : pcs_pkg::TOL_BITS) + 2;
  localparam int RB       = pcs_pkg::RUN_BITS;
  localparam logic [CB-1:0] CAP = {1'b1, {(CB-1){1'b0}}};

  // Configuration
  logic [pcs_pkg::TOL_BITS-1:0]   tol_q;
  logic [pcs_pkg::LIMIT_BITS-1:0] limit_q;

  // Line state
  pcs_pkg::state_e        state_q, state_d;
  pcs_pkg::point_t        item_q;
  logic signed [CB-1:0]   anchor_x_q, anchor_y_q, prev_x_q, prev_y_q;
  logic [1:0]             seen_q;
  logic [RB-1:0]          run_q;

  // Divider
  logic                   sel_q;
  logic signed [DW-1:0]   dx_q, dy_q;
  logic [DW-1:0]          mx_q, num_q, r_q;
  logic [CB-1:0]          q_q;
  logic                   neg_q, zero_q;
  logic [CNT_BITS-1:0]    cnt_q;

  // Slopes and decision
  logic signed [CB-1:0]   s1_q, s2_q;
  logic                   ok1_q, ok2_q;
  logic signed [DW-1:0]   d_q;

  // Output register
  logic                   out_valid_q;
  pcs_pkg::kept_t         out_q;

  logic                   in_accept, out_take, out_load;
  logic signed [DW-1:0]   dx_d, dy_d;
  logic [DW-1:0]          mx_d, my_d;
  logic [DW:0]            r_sh;
  logic [DW-1:0]          r_sub;
  logic                   r_ge;
  logic [DW-1:0]          r_d;
  logic [CB:0]            q_sh;
  logic [CB-1:0]          q_d;
  logic signed [CB-1:0]   slope_d;
  logic signed [CW-1:0]   d_ext, tol_ext, d_sum;
  logic                   same_w, keep_w;
  logic [RB-1:0]          count_w;

  // Handshake and sequencer outputs
  always_comb begin
    in_stall_o = (state_q != pcs_pkg::ST_IDLE);
    in_accept  = in_valid_i && !in_stall_o;
    out_take   = out_valid_q && !out_stall_i;
    out_load   = ((state_q == pcs_pkg::ST_EMIT_PREV) || (state_q == pcs_pkg::ST_EMIT_ITEM))
                 && (!out_valid_q || !out_stall_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Differences from the anchor for the selected slope
  always_comb begin
    if (sel_q) begin
      dx_d = DW'(item_q.point_x) - DW'(anchor_x_q);
      dy_d = DW'(item_q.point_y) - DW'(anchor_y_q);
    end else begin
      dx_d = DW'(prev_x_q) - DW'(anchor_x_q);
      dy_d = DW'(prev_y_q) - DW'(anchor_y_q);
    end
    mx_d = dx_q[DW-1] ? (DW'(~dx_q) + DW'(1)) : DW'(dx_q);
    my_d = dy_q[DW-1] ? (DW'(~dy_q) + DW'(1)) : DW'(dy_q);
  end

  // One restoring divider step, quotient clamped at the cap
  always_comb begin
    r_sh  = {r_q, num_q[DW-1]};
    r_sub = r_sh[DW-1:0] - mx_q;
    r_ge  = (r_sh >= {1'b0, mx_q});
    r_d   = r_ge ? r_sub : r_sh[DW-1:0];
    q_sh  = {q_q, r_ge};
    q_d   = (q_sh > {1'b0, CAP}) ? CAP : q_sh[CB-1:0];
  end

  // Signed, saturated slope from the magnitude quotient
  always_comb begin
    if (neg_q) begin
      slope_d = CB'(~q_q) + CB'(1);
    end else if (q_q == CAP) begin
      slope_d = CAP - CB'(1);
    end else begin
      slope_d = q_q;
    end
  end

  // Tolerance window and run limit
  always_comb begin
    d_ext   = CW'(d_q);
    tol_ext = CW'($signed({1'b0, tol_q}));
    d_sum   = d_ext + tol_ext;
    same_w  = ok1_q && ok2_q && (d_ext <= tol_ext) && !d_sum[CW-1];
    count_w = run_q + RB'(1);
    keep_w  = !same_w || (count_w > RB'(limit_q));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcs_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (seen_q)
            2'd0:    state_d = pcs_pkg::ST_EMIT_ITEM;
            2'd1:    state_d = in_data_i.final_point ? pcs_pkg::ST_EMIT_ITEM
                                                     : pcs_pkg::ST_IDLE;
            default: state_d = pcs_pkg::ST_DIFF;
          endcase
        end
      end
      pcs_pkg::ST_DIFF:  state_d = pcs_pkg::ST_MAG;
      pcs_pkg::ST_MAG:   state_d = pcs_pkg::ST_DIV;
      pcs_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = pcs_pkg::ST_FIX;
      end
      pcs_pkg::ST_FIX:   state_d = sel_q ? pcs_pkg::ST_SDIFF : pcs_pkg::ST_DIFF;
      pcs_pkg::ST_SDIFF: state_d = pcs_pkg::ST_DECIDE;
      pcs_pkg::ST_DECIDE: begin
        if (keep_w) begin
          state_d = pcs_pkg::ST_EMIT_PREV;
        end else if (item_q.final_point) begin
          state_d = pcs_pkg::ST_EMIT_ITEM;
        end else begin
          state_d = pcs_pkg::ST_IDLE;
        end
      end
      pcs_pkg::ST_EMIT_PREV: begin
        if (out_load) begin
          state_d = item_q.final_point ? pcs_pkg::ST_EMIT_ITEM : pcs_pkg::ST_IDLE;
        end
      end
      pcs_pkg::ST_EMIT_ITEM: begin
        if (out_load) state_d = pcs_pkg::ST_IDLE;
      end
      default: state_d = pcs_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= '0;
      limit_q <= pcs_pkg::RUN_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcs_pkg::CFG_SLOPE_TOL: tol_q   <= cfg_data_i[pcs_pkg::TOL_BITS-1:0];
        pcs_pkg::CFG_RUN_LIMIT: limit_q <= cfg_data_i[pcs_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pcs_pkg::ST_IDLE;
      seen_q     <= '0;
      run_q      <= '0;
      sel_q      <= 1'b0;
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        pcs_pkg::ST_IDLE: begin
          if (in_accept) begin
            sel_q <= 1'b0;
            case (seen_q)
              2'd0: begin
                anchor_x_q <= in_data_i.point_x;
                anchor_y_q <= in_data_i.point_y;
                prev_x_q   <= in_data_i.point_x;
                prev_y_q   <= in_data_i.point_y;
                run_q      <= '0;
                seen_q     <= in_data_i.final_point ? 2'd0 : 2'd1;
              end
              2'd1: begin
                prev_x_q <= in_data_i.point_x;
                prev_y_q <= in_data_i.point_y;
                run_q    <= '0;
                seen_q   <= in_data_i.final_point ? 2'd0 : 2'd2;
              end
              default: ;
            endcase
          end
        end
        pcs_pkg::ST_FIX: sel_q <= 1'b1;
        pcs_pkg::ST_DECIDE: begin
          // advance the anchor to the previous point when it is kept
          if (keep_w) begin
            anchor_x_q <= prev_x_q;
            anchor_y_q <= prev_y_q;
          end
          prev_x_q <= item_q.point_x;
          prev_y_q <= item_q.point_y;
          // clear the run on a kept point or at the end of the line
          if (item_q.final_point) begin
            seen_q <= 2'd0;
            run_q  <= '0;
          end else if (keep_w) begin
            run_q <= '0;
          end else begin
            run_q <= count_w;
          end
        end
        default: ;
      endcase
    end
  end

  // Point register, divider and slope datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) item_q <= in_data_i;
    case (state_q)
      pcs_pkg::ST_DIFF: begin
        dx_q <= dx_d;
        dy_q <= dy_d;
      end
      pcs_pkg::ST_MAG: begin
        mx_q   <= mx_d;
        num_q  <= my_d;
        neg_q  <= dx_q[DW-1] ^ dy_q[DW-1];
        zero_q <= (dx_q == '0);
        r_q    <= '0;
        q_q    <= '0;
        cnt_q  <= CNT_BITS'(NUM_BITS - 1);
      end
      pcs_pkg::ST_DIV: begin
        // shift in one dividend bit, retire one quotient bit
        num_q <= {num_q[DW-2:0], 1'b0};
        r_q   <= r_d;
        q_q   <= q_d;
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
      pcs_pkg::ST_FIX: begin
        if (sel_q) begin
          s2_q  <= slope_d;
          ok2_q <= !zero_q;
        end else begin
          s1_q  <= slope_d;
          ok1_q <= !zero_q;
        end
      end
      pcs_pkg::ST_SDIFF: d_q <= DW'(s1_q) - DW'(s2_q);
      default: ;
    endcase
  end

  // Output register: hold while stalled, load the next kept point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == pcs_pkg::ST_EMIT_PREV) begin
        out_q.kept_x      <= anchor_x_q;
        out_q.kept_y      <= anchor_y_q;
        out_q.end_of_line <= 1'b0;
      end else begin
        out_q.kept_x      <= item_q.point_x;
        out_q.kept_y      <= item_q.point_y;
        out_q.end_of_line <= item_q.final_point;
      end
    end
  end

endmodule

`default_nettype wire

[src/pcs_checker.sv]
// Port-level checker for the polyline collinear simplifier, bound to the top level.
`default_nettype none

module pcs_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire pcs_pkg::kept_t                     out_data_o
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed or vanished");

  // a new output word only comes from a busy cycle
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word appeared while the block was idle");

  // a follow-on word right after a take needs a busy cycle
  a_out_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o || $past(in_stall_o))
    else $error("output register refilled without a pending kept point");

  // an idle block with an empty output register stays empty until a point arrives
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !in_valid_i && !out_valid_o |=> !out_valid_o)
    else $error("output word produced with no point taken");

endmodule

bind polyline_collinear_simplifier pcs_checker u_pcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[bench/polyline_collinear_simplifier_tb.sv]
// Self-checking testbench for the polyline collinear simplifier.
`timescale 1ns / 100ps

module polyline_collinear_simplifier_tb;

  localparam int NUM_BITS       = pcs_pkg::COORD_BITS + 1 + pcs_pkg::FRAC_BITS;
  localparam int SETTLE_CYCLES  = 160;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LINES   = 100;

  // Indexes that decode to no register
  localparam logic [pcs_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_A = pcs_pkg::CFG_ADDR_BITS'(2);
  localparam logic [pcs_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_B = pcs_pkg::CFG_ADDR_BITS'(3);

  typedef enum int {LINE_STRAIGHT, LINE_CLEAN, LINE_NOISE, LINE_EXTREME} line_style_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  pcs_pkg::point_t                   in_data  = '0;
  logic                              in_stall;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  pcs_pkg::kept_t                    out_data;
  logic                              cfg_we   = 1'b0;
  logic [pcs_pkg::CFG_ADDR_BITS-1:0] cfg_idx  = '0;
  logic [pcs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // Words waiting to be sent, kept points waiting to arrive
  pcs_pkg::point_t point_queue[$];
  pcs_pkg::kept_t  kept_expected[$];
  int     words_queued = 0;
  int     words_taken  = 0;
  int     mismatches   = 0;
  int     idle_cycles  = 0;
  int     burst_left   = 1;
  int     gap_left     = 0;
  int     stall_run    = 0;

  // Shadow of the block's registers and line state
  logic [pcs_pkg::TOL_BITS-1:0]   tol_m   = '0;
  logic [pcs_pkg::LIMIT_BITS-1:0] limit_m = pcs_pkg::RUN_LIMIT_RESET;
  longint                anchor_x = 0, anchor_y = 0, prev_x = 0, prev_y = 0;
  int                    pts_seen = 0;
  logic [pcs_pkg::RUN_BITS-1:0]   run_cnt  = '0;

  polyline_collinear_simplifier dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LINES) $display("ERROR: %s at %0t", what, $time);
  endtask

  // Restoring division of |dy| << FRAC_BITS by |dx|, saturated to the signed coordinate range
  function automatic logic slope_q16(input longint dx, input longint dy, output longint s);
    longint unsigned mx, my, r, q, cap, bitv;
    logic neg;
    s = 0;
    if (dx == 0) return 1'b0;
    mx  = (dx < 0) ? longint'(-dx) : dx;
    my  = (dy < 0) ? longint'(-dy) : dy;
    neg = (dx < 0) != (dy < 0);
    cap = 64'd1 << (pcs_pkg::COORD_BITS - 1);
    r = 0;
    q = 0;
    for (int i = NUM_BITS - 1; i >= 0; i--) begin
      bitv = (i >= pcs_pkg::FRAC_BITS) ? ((my >> (i - pcs_pkg::FRAC_BITS)) & 64'd1) : 64'd0;
      r = (r << 1) | bitv;
      q = q << 1;
      if (r >= mx) begin
        r = r - mx;
        q = q | 64'd1;
      end
      if (q > cap) q = cap;
    end
    if (neg) begin
      s = -longint'(q);
    end else begin
      if (q > cap - 1) q = cap - 1;
      s = longint'(q);
    end
    return 1'b1;
  endfunction

  task automatic keep_point(input longint x, input longint y, input logic eol);
    pcs_pkg::kept_t k;
    k.kept_x      = x[pcs_pkg::COORD_BITS-1:0];
    k.kept_y      = y[pcs_pkg::COORD_BITS-1:0];
    k.end_of_line = eol;
    kept_expected = {kept_expected, k};
  endtask

  // Advance the line state by one accepted point and queue the points it keeps
  task automatic track_polyline(input pcs_pkg::point_t p);
    longint x, y, s_prev, s_new, d;
    longint unsigned ad;
    logic ok_prev, ok_new, same;
    logic [pcs_pkg::RUN_BITS-1:0] count;
    x = longint'($signed(p.point_x));
    y = longint'($signed(p.point_y));
    if (pts_seen == 0) begin
      keep_point(x, y, p.final_point);
      anchor_x = x;
      anchor_y = y;
      prev_x   = x;
      prev_y   = y;
      run_cnt  = '0;
      pts_seen = p.final_point ? 0 : 1;
    end else if (pts_seen == 1) begin
      prev_x  = x;
      prev_y  = y;
      run_cnt = '0;
      if (p.final_point) begin
        keep_point(x, y, 1'b1);
        pts_seen = 0;
      end else begin
        pts_seen = 2;
      end
    end else begin
      ok_prev = slope_q16(prev_x - anchor_x, prev_y - anchor_y, s_prev);
      ok_new  = slope_q16(x - anchor_x, y - anchor_y, s_new);
      count   = run_cnt + 1'b1;
      same    = 1'b0;
      if (ok_prev && ok_new) begin
        d    = s_prev - s_new;
        ad   = (d < 0) ? longint'(-d) : d;
        same = (ad <= tol_m);
      end
      if (!same || count > limit_m) begin
        keep_point(prev_x, prev_y, 1'b0);
        anchor_x = prev_x;
        anchor_y = prev_y;
        run_cnt  = '0;
      end else begin
        run_cnt = count;
      end
      prev_x = x;
      prev_y = y;
      if (p.final_point) begin
        keep_point(x, y, 1'b1);
        pts_seen = 0;
        run_cnt  = '0;
      end
    end
  endtask

  task automatic queue_point(input logic [pcs_pkg::COORD_BITS-1:0] x,
                             input logic [pcs_pkg::COORD_BITS-1:0] y,
                             input logic fin);
    pcs_pkg::point_t p;
    p.point_x     = x;
    p.point_y     = y;
    p.final_point = fin;
    point_queue = {point_queue, p};
    words_queued++;
  endtask

  function automatic logic [pcs_pkg::COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Build one polyline; an open line leaves its last point unflagged
  task automatic queue_line(input int len, input line_style_e st, input bit closed);
    int cx, cy, sx, sy, jy;
    logic fin;
    cx = int'($urandom) >>> 7;
    cy = int'($urandom) >>> 7;
    sx = int'($urandom) >>> 20;
    sy = int'($urandom) >>> 20;
    if (st != LINE_CLEAN && $urandom_range(0, 15) == 0) sx = 0;
    if (st == LINE_CLEAN && sx == 0) sx = 1;
    for (int k = 0; k < len; k++) begin
      fin = closed && (k == len - 1);
      case (st)
        LINE_NOISE:   queue_point($urandom, $urandom, fin);
        LINE_EXTREME: queue_point(extreme_coord(), extreme_coord(), fin);
        default: begin
          jy = 0;
          if (st == LINE_STRAIGHT && $urandom_range(0, 7) == 0) begin
            sx = int'($urandom) >>> 20;
            sy = int'($urandom) >>> 20;
          end
          if (st == LINE_STRAIGHT && $urandom_range(0, 3) == 0)
            jy = int'($urandom_range(0, 6)) - 3;
          queue_point(cx, cy + jy, fin);
          cx += sx;
          cy += sy;
        end
      endcase
    end
  endtask

  task automatic queue_random_lines(input int n, input bit leave_open);
    int start, len;
    line_style_e st;
    start = words_queued;
    while (words_queued - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: st = LINE_STRAIGHT;
        4:          st = LINE_CLEAN;
        5, 6:       st = LINE_NOISE;
        default:    st = LINE_EXTREME;
      endcase
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      queue_line(len, st, 1'b1);
    end
    if (leave_open) queue_line(4, LINE_STRAIGHT, 1'b0);
  endtask

  // Hold until every word is taken and every kept point is back, then let the block settle
  task automatic wait_for_quiet();
    while (words_taken != words_queued || kept_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcs_pkg::CFG_ADDR_BITS-1:0] idx,
                           input logic [pcs_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      pcs_pkg::CFG_SLOPE_TOL: tol_m   = data[pcs_pkg::TOL_BITS-1:0];
      pcs_pkg::CFG_RUN_LIMIT: limit_m = data[pcs_pkg::LIMIT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Driver: take the accepted word into the shadow, then present the next one in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        track_polyline(in_data);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_data  <= point_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 130)
                                                     : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternate free and stalled stretches of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 600)
                                              : $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b1;
      stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
    end
  end

  // Monitor: compare each accepted kept word with the oldest expected one
  always @(posedge clk) begin
    pcs_pkg::kept_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (kept_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected kept word %h", out_data));
      end else begin
        want = kept_expected.pop_front();
        if (out_data.kept_x !== want.kept_x)
          report_mismatch($sformatf("kept_x got %h want %h", out_data.kept_x, want.kept_x));
        if (out_data.kept_y !== want.kept_y)
          report_mismatch($sformatf("kept_y got %h want %h", out_data.kept_y, want.kept_y));
        if (out_data.end_of_line !== want.end_of_line)
          report_mismatch($sformatf("end_of_line got %b want %b",
                                    out_data.end_of_line, want.end_of_line));
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("polyline_collinear_simplifier regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [pcs_pkg::CFG_DATA_BITS-1:0] tol_w, lim_w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines under the reset settings
    // single-point line at the coordinate extremes
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // two-point line
    queue_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    // vertical line: zero x difference, last point also ends the run
    queue_point(32'h0, 32'h0, 1'b0);
    queue_point(32'h0, 32'h0001_0000, 1'b0);
    queue_point(32'h0, 32'h0002_0000, 1'b1);
    // long collinear line that trips the run limit
    for (int k = 0; k < 14; k++) queue_point(32'(k * 65536), 32'(k * 3 * 65536), k == 13);
    // steep slopes that saturate the quotient
    queue_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_point(32'h8000_0001, 32'h7FFF_FFFF, 1'b0);
    queue_point(32'h8000_0002, 32'h8000_0000, 1'b1);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      wait_for_quiet();
      case (ph)
        0: begin tol_w = '0;                          lim_w = '0;                   end
        1: begin tol_w = 32'hFFFF_FFFF;               lim_w = 32'h3FF;              end
        2: begin tol_w = $urandom_range(0, 32'h3FFFF); lim_w = $urandom_range(1, 6); end
        3: begin tol_w = 32'hFFFF_FFFF;               lim_w = 32'd3;                end
        4: begin tol_w = $urandom;                    lim_w = $urandom;             end
        5: begin tol_w = $urandom_range(0, 255);      lim_w = 32'd10;               end
        default: begin tol_w = '0;                    lim_w = 32'hFFFF_FFFF;        end
      endcase
      write_reg(pcs_pkg::CFG_SLOPE_TOL, tol_w);
      write_reg(pcs_pkg::CFG_RUN_LIMIT, lim_w);
      if (ph == 4) begin
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
      end
      @(posedge clk);
      cfg_we <= 1'b0;
      // one line long enough to pass the widest run limit
      if (ph == 1) queue_line(1030, LINE_CLEAN, 1'b1);
      queue_random_lines(76, ph != 6);
    end

    wait_for_quiet();
    if (mismatches == 0 && kept_expected.size() == 0) begin
      $display("polyline_collinear_simplifier regression: pass");
    end else begin
      $display("polyline_collinear_simplifier regression: fail");
    end
    $finish;
  end

endmodule
